[src/lcs_pkg.sv]
package lcs_pkg;

	// default capacity of the first-sequence store
	localparam int MAX_LEN_DEF = 16;
	// widest capacity the wave fields are sized for
	localparam int MAX_LEN_HI  = 256;
	localparam int WAVE_W      = $clog2(MAX_LEN_HI + 1);

	// func codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_FEED = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] symbol;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [4:0] lcs_length;
		logic       overflow;
	} result_t;

	// one second-sequence symbol travelling along the row of cells
	typedef struct packed {
		logic              vld;
		logic              last;
		logic [7:0]        sym;
		logic [WAVE_W-1:0] lim;   // stored symbol count when the item entered
		logic [WAVE_W-1:0] diag;  // old score of the cell to the left
		logic [WAVE_W-1:0] left;  // new score of the cell to the left
	} wave_t;

endpackage

[src/lcs_length_engine.sv]
// lcs_length_engine: length of the longest common subsequence of two byte
// sequences, computed by a row of MAX_LEN cells.
// Input: an item is taken at a clock edge with start high and busy low.
//   func = load stores a first-sequence symbol in the next free cell; loads
//   past MAX_LEN are dropped and flagged. func = feed sends a second-sequence
//   symbol into cell 0; it moves one cell per cycle, updating each stored
//   score on the way. Loads and feeds without last go at one per cycle while busy is low.
// Output: done is high for exactly one cycle with result valid; the receiver
//   cannot stall it and must take it in that cycle.
// Final item: a feed with last set makes busy high from the next cycle; the
//   item crosses the row of MAX_LEN cells, done rises as it leaves the last
//   cell and busy falls in the cycle after done, so a pair's final
//   item holds the block until the result has been given.
// After the result the symbol count and overflow flag clear, ready for the
// next pair. Reset (arst_n low) empties the store and clears all flags.
module lcs_length_engine import lcs_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	localparam int CW = $clog2(MAX_LEN + 1);

	logic          busy_q;
	logic          dropped_q;
	logic [CW-1:0] count_q;
	logic          acc;
	logic          load_acc;
	logic          feed_acc;
	logic          full;
	wave_t         wave_head;
	wave_t         wave [MAX_LEN];

	assign acc      = start && !busy_q;
	assign load_acc = acc && (item.func == FUNC_LOAD);
	assign feed_acc = acc && (item.func == FUNC_FEED);
	assign full     = (count_q == CW'(MAX_LEN));

	// item entering cell 0
	always_comb begin
		wave_head.vld  = feed_acc;
		wave_head.last = item.last;
		wave_head.sym  = item.symbol;
		wave_head.lim  = WAVE_W'(count_q);
		wave_head.diag = '0;
		wave_head.left = '0;
	end

	// row of cells
	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		lcs_cell #(.K(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load_en  (load_acc && (count_q == CW'(k))),
			.load_sym (item.symbol),
			.wave_in  ((k == 0) ? wave_head : wave[(k == 0) ? 0 : k - 1]),
			.wave_out (wave[k])
		);
	end

	// result leaves the end of the row
	assign done              = wave[MAX_LEN-1].vld && wave[MAX_LEN-1].last;
	assign result.lcs_length = wave[MAX_LEN-1].left[4:0];
	assign result.overflow   = dropped_q;
	assign busy              = busy_q;

	// fill count, overflow flag, busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			busy_q    <= 1'b0;
		end else begin
			if (done) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
				busy_q    <= 1'b0;
			end else begin
				if (load_acc) begin
					if (full) begin
						dropped_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				if (feed_acc && item.last) begin
					busy_q <= 1'b1;
				end
			end
		end
	end

	// checks
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("result strobe outside busy window");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(feed_acc && item.last) |=> busy_q)
		else $error("busy not raised after final item");

	a_clear_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy_q && count_q == '0 && !dropped_q))
		else $error("state not cleared after result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LEN))
		else $error("symbol count beyond capacity");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (wave[MAX_LEN-1].left <= wave[MAX_LEN-1].lim))
		else $error("length exceeds stored symbol count");

endmodule

[src/lcs_cell.sv]
module lcs_cell import lcs_pkg::*; #(
	parameter int K = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load_en,
	input  logic [7:0] load_sym,
	input  wave_t      wave_in,
	output wave_t      wave_out
);

	logic [7:0]        sym_q;
	logic [WAVE_W-1:0] score_q;
	logic              vld_q;
	logic              last_q;
	logic [7:0]        wsym_q;
	logic [WAVE_W-1:0] lim_q;
	logic [WAVE_W-1:0] diag_q;
	logic [WAVE_W-1:0] left_q;
	logic              active;
	logic [WAVE_W-1:0] best;
	logic [WAVE_W-1:0] val;

	// cell takes part only if it held a symbol when the item entered
	assign active = wave_in.vld && (WAVE_W'(K) < wave_in.lim);

	// match: diagonal plus one, else the larger neighbour
	always_comb begin
		best = (wave_in.left > score_q) ? wave_in.left : score_q;
		val  = (sym_q == wave_in.sym) ? wave_in.diag + WAVE_W'(1) : best;
	end

	// stored symbol and score
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
		end else if (load_en) begin
			score_q <= '0;
		end else if (active) begin
			score_q <= val;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			sym_q <= load_sym;
		end
	end

	// hand the item on; idle cells pass the left score through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= wave_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= wave_in.last;
		wsym_q <= wave_in.sym;
		lim_q  <= wave_in.lim;
		diag_q <= score_q;
		left_q <= active ? val : wave_in.left;
	end

	always_comb begin
		wave_out.vld  = vld_q;
		wave_out.last = last_q;
		wave_out.sym  = wsym_q;
		wave_out.lim  = lim_q;
		wave_out.diag = diag_q;
		wave_out.left = left_q;
	end

endmodule
